/* hdl/rthsi_pkg.sv */
package rthsi_pkg;

    localparam int CORDIC_W     = 42;
    localparam int CORDIC_STEPS = 32;
    localparam int ANGLE_W      = 32;
    localparam int DEN_W        = 11;

    typedef logic signed [CORDIC_W-1:0] cval_t;
    typedef logic [ANGLE_W-1:0]         angle_t;

    // sqrt(3) in Q30
    localparam logic [31:0] SQRT3_Q30   = 32'd1859775393;
    localparam angle_t      HALF_TURN   = 32'h8000_0000;

    // rounded channel mean: floor((sum * full + 382) / 765)
    localparam int          INTEN_DIV   = 765;
    localparam logic [9:0]  INTEN_HALF  = 10'd382;
    // ceil(2^30 / 765); exact for dividends below 2^20
    localparam logic [20:0] INTEN_RECIP = 21'd1403585;
    localparam int          INTEN_SHIFT = 30;

    // atan(2^-i) in units of 2^-32 turn
    localparam angle_t ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // arithmetic shift right that truncates toward zero
    function automatic cval_t shift_tz(input cval_t v, input int s);
        cval_t mag;
        mag = v[CORDIC_W-1] ? -v : v;
        mag = cval_t'(mag >> s);
        return v[CORDIC_W-1] ? -mag : mag;
    endfunction

endpackage

/* hdl/rthsi_if.sv */
interface rthsi_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rthsi_hsi_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] hue;
    logic [W-1:0] saturation;
    logic [W-1:0] intensity;

    modport source (output valid, output hue, output saturation, output intensity,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input intensity,
                    output ready);
endinterface

/* hdl/rthsi_cordic.sv */
// Hue: vectoring CORDIC, one iteration per stage.
module rthsi_cordic #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [7:0]               red,
    input  logic [7:0]               green,
    input  logic [7:0]               blue,
    output logic [FRACTION_BITS-1:0] hue
);

    localparam int N = rthsi_pkg::CORDIC_STEPS;

    rthsi_pkg::cval_t  x_reg   [N+1];
    rthsi_pkg::cval_t  y_reg   [N+1];
    rthsi_pkg::angle_t acc_reg [N+1];
    logic              gray_reg [N+1];
    logic [FRACTION_BITS-1:0] hue_reg;

    logic signed [10:0] xd;
    logic signed [8:0]  yd;
    rthsi_pkg::cval_t   x0;
    rthsi_pkg::cval_t   y0;
    rthsi_pkg::angle_t  rsum;

    assign xd = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
              - $signed({3'b000, blue});
    assign yd = $signed({1'b0, green}) - $signed({1'b0, blue});
    assign x0 = rthsi_pkg::cval_t'(xd) <<< 30;
    assign y0 = rthsi_pkg::cval_t'(yd)
              * rthsi_pkg::cval_t'($signed({1'b0, rthsi_pkg::SQRT3_Q30}));

    // prep stage: fold left half plane onto the right
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0[rthsi_pkg::CORDIC_W-1] ? -x0 : x0;
            y_reg[0]    <= x0[rthsi_pkg::CORDIC_W-1] ? -y0 : y0;
            acc_reg[0]  <= x0[rthsi_pkg::CORDIC_W-1] ? rthsi_pkg::HALF_TURN : '0;
            gray_reg[0] <= (red == green) && (green == blue);
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        rthsi_pkg::cval_t xs;
        rthsi_pkg::cval_t ys;
        assign xs = rthsi_pkg::shift_tz(x_reg[i], i);
        assign ys = rthsi_pkg::shift_tz(y_reg[i], i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][rthsi_pkg::CORDIC_W-1])
                begin
                    x_reg[i+1]   <= x_reg[i] + ys;
                    y_reg[i+1]   <= y_reg[i] - xs;
                    acc_reg[i+1] <= acc_reg[i] + rthsi_pkg::ATAN_TURN[i];
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] - ys;
                    y_reg[i+1]   <= y_reg[i] + xs;
                    acc_reg[i+1] <= acc_reg[i] - rthsi_pkg::ATAN_TURN[i];
                end
                gray_reg[i+1] <= gray_reg[i];
            end
        end
    end

    // round to FRACTION_BITS; a full turn wraps through the 32-bit add
    assign rsum = acc_reg[N] + (rthsi_pkg::angle_t'(1) << (31 - FRACTION_BITS));

    always_ff @(posedge clk)
    begin
        if (en)
            hue_reg <= gray_reg[N] ? '0 : rsum[31 -: FRACTION_BITS];
    end

    assign hue = hue_reg;

endmodule

/* hdl/rthsi_div.sv */
// Restoring divider, one quotient bit per stage. Needs num < den * 2^QW.
module rthsi_div #(
    parameter int QW = 16,
    parameter int NW = 27,
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int B = QW - 1 - k;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic [NW-1:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign trial = NW'(den_in) << B;
        assign ge    = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? rem_in - trial : rem_in;
                den_reg[k] <= den_in;
                q_reg[k]   <= q_in | (QW'(ge) << B);
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

/* hdl/rgb_to_hsi_pixel.sv */
// RGB to HSI pixel converter.
// Throughput: one pixel per cycle; the 32-stage hue CORDIC sets the depth.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Reset (rst_n, async low) clears the valid bits only; no clearing pass.
module rgb_to_hsi_pixel #(
    parameter int FRACTION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    rthsi_pix_if.sink         pix,
    rthsi_hsi_if.source       hsi
);

    localparam int FB  = FRACTION_BITS;
    localparam int NW  = FB + 11;                     // dividend width
    localparam int LAT = rthsi_pkg::CORDIC_STEPS + 3; // valid chain length
    localparam int DLY = rthsi_pkg::CORDIC_STEPS + 1 - FB; // align dividers to hue
    localparam int IDLY = LAT - 3;                    // intensity is ready early

    // full * sum = 765 * (sum * HI_K) + sum * LO_K
    localparam longint        FULL    = (longint'(1) << FB) - 1;
    localparam logic [FB-1:0] INT_HI_K = FB'(FULL / rthsi_pkg::INTEN_DIV);
    localparam logic [9:0]    INT_LO_K = 10'(FULL % rthsi_pkg::INTEN_DIV);

    logic           adv;
    logic [LAT-1:0] vld_reg;

    // input register
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    // divider prep
    logic [9:0]             sum;
    logic [7:0]             mn;
    logic [9:0]             diff;
    logic [NW-1:0]          sat_num_next;
    logic [NW-1:0]          sat_num_reg;
    logic [rthsi_pkg::DEN_W-1:0] sat_den_reg;

    // intensity: whole part by constant product, rest by reciprocal
    logic [FB-1:0] int_hi_next;
    logic [19:0]   int_lo_next;
    logic [FB-1:0] int_hi_reg;
    logic [19:0]   int_lo_reg;
    logic [FB-1:0] int_hi2_reg;
    logic [40:0]   int_prod_reg;

    logic [FB-1:0] hue_q;
    logic [FB-1:0] sat_q;
    logic [FB-1:0] sat_dly_reg [DLY];
    logic [FB-1:0] int_dly_reg [IDLY];

    // global pipeline enable: stall only when the result register is held
    assign adv       = !vld_reg[LAT-1] || hsi.ready;
    assign pix.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], pix.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= pix.red;
            green_reg <= pix.green;
            blue_reg  <= pix.blue;
        end
    end

    assign sum  = 10'(red_reg) + 10'(green_reg) + 10'(blue_reg);
    assign mn   = (red_reg < green_reg)
                ? ((red_reg < blue_reg) ? red_reg : blue_reg)
                : ((green_reg < blue_reg) ? green_reg : blue_reg);
    assign diff = sum - 10'(3 * mn);

    // x * (2^FB - 1) * 2 as shifts; sum == 0 gives num 0 over den 1
    assign sat_num_next = ((((NW'(diff)) << FB) - NW'(diff)) << 1) + NW'(sum);

    // sum * LO_K + 382 stays below 2^20
    assign int_hi_next = FB'(sum) * INT_HI_K;
    assign int_lo_next = 20'(sum) * 20'(INT_LO_K) + 20'(rthsi_pkg::INTEN_HALF);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_num_reg <= sat_num_next;
            sat_den_reg <= (sum == '0) ? rthsi_pkg::DEN_W'(1)
                                       : {sum, 1'b0};
            int_hi_reg  <= int_hi_next;
            int_lo_reg  <= int_lo_next;
        end
    end

    // divide the remainder part by 765 through the reciprocal
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            int_prod_reg <= 41'(int_lo_reg) * 41'(rthsi_pkg::INTEN_RECIP);
            int_hi2_reg  <= int_hi_reg;
        end
    end

    rthsi_cordic #(.FRACTION_BITS(FB)) u_cordic (
        .clk   (clk),
        .en    (adv),
        .red   (red_reg),
        .green (green_reg),
        .blue  (blue_reg),
        .hue   (hue_q)
    );

    rthsi_div #(.QW(FB), .NW(NW), .DW(rthsi_pkg::DEN_W)) u_sat_div (
        .clk   (clk),
        .en    (adv),
        .num   (sat_num_reg),
        .den   (sat_den_reg),
        .quo   (sat_q)
    );

    // delay the shorter paths to line up with the hue
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_dly_reg[0] <= sat_q;
            for (int i = 1; i < DLY; i++)
                sat_dly_reg[i] <= sat_dly_reg[i-1];
            int_dly_reg[0] <= int_hi2_reg
                            + FB'(int_prod_reg >> rthsi_pkg::INTEN_SHIFT);
            for (int i = 1; i < IDLY; i++)
                int_dly_reg[i] <= int_dly_reg[i-1];
        end
    end

    assign hsi.valid      = vld_reg[LAT-1];
    assign hsi.hue        = hue_q;
    assign hsi.saturation = sat_dly_reg[DLY-1];
    assign hsi.intensity  = int_dly_reg[IDLY-1];

    // a held result must freeze the input side
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (hsi.valid && !hsi.ready) |-> !pix.ready)
        else $error("request taken while result stalled");

    // a result only appears after the stage before it held one
    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hsi.valid) |-> $past(vld_reg[LAT-2]))
        else $error("result valid without upstream request");

endmodule
